/* rtl/core/isodr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// isodr_pkg
// Types and constants shared by the directory record checker: record field
// offsets, verdict codes and the structs passed between the capture and
// verdict logic.
// ----------------------------------------------------------------------------
package isodr_pkg;

	// fixed layout of a directory record
	localparam logic [7:0] MIN_RECORD  = 8'd34;
	localparam logic [7:0] NAME_START  = 8'd33;

	localparam logic [7:0] POS_LENGTH     = 8'd0;
	localparam logic [7:0] POS_EXT_ATTR   = 8'd1;
	localparam logic [7:0] POS_EXT_LE0    = 8'd2;
	localparam logic [7:0] POS_EXT_LE1    = 8'd3;
	localparam logic [7:0] POS_EXT_LE2    = 8'd4;
	localparam logic [7:0] POS_EXT_LE3    = 8'd5;
	localparam logic [7:0] POS_EXT_BE0    = 8'd6;
	localparam logic [7:0] POS_EXT_BE1    = 8'd7;
	localparam logic [7:0] POS_EXT_BE2    = 8'd8;
	localparam logic [7:0] POS_EXT_BE3    = 8'd9;
	localparam logic [7:0] POS_SIZE_LE0   = 8'd10;
	localparam logic [7:0] POS_SIZE_LE1   = 8'd11;
	localparam logic [7:0] POS_SIZE_LE2   = 8'd12;
	localparam logic [7:0] POS_SIZE_LE3   = 8'd13;
	localparam logic [7:0] POS_SIZE_BE0   = 8'd14;
	localparam logic [7:0] POS_SIZE_BE1   = 8'd15;
	localparam logic [7:0] POS_SIZE_BE2   = 8'd16;
	localparam logic [7:0] POS_SIZE_BE3   = 8'd17;
	localparam logic [7:0] POS_FLAGS      = 8'd25;
	localparam logic [7:0] POS_UNIT_SIZE  = 8'd26;
	localparam logic [7:0] POS_GAP_SIZE   = 8'd27;
	localparam logic [7:0] POS_SEQ_LE0    = 8'd28;
	localparam logic [7:0] POS_SEQ_LE1    = 8'd29;
	localparam logic [7:0] POS_SEQ_BE0    = 8'd30;
	localparam logic [7:0] POS_SEQ_BE1    = 8'd31;
	localparam logic [7:0] POS_IDENT_LEN  = 8'd32;

	localparam int FLAG_DIRECTORY  = 1;
	localparam int FLAG_MULTI      = 7;

	localparam logic [15:0] SUFFIX_VERSION = 16'h3B31;  // ";1"
	localparam logic [7:0]  CHAR_LOW       = 8'h20;
	localparam logic [7:0]  CHAR_HIGH      = 8'h7E;
	localparam logic [7:0]  CHAR_SLASH     = 8'h2F;
	localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0]  CHAR_COLON     = 8'h3A;
	localparam logic [7:0]  CHAR_DOT       = 8'h2E;
	localparam logic [7:0]  CHAR_SPACE     = 8'h20;
	localparam logic [7:0]  IDENT_DOT      = 8'h00;
	localparam logic [7:0]  IDENT_DOT_DOT  = 8'h01;

	// verdict codes
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_INVALID     = 2'd1;
	localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;
	localparam logic [1:0] STAT_UNSAFE      = 2'd3;

	localparam logic [5:0] OFS_NONE     = 6'd0;
	localparam logic [5:0] OFS_EXTENT   = 6'd2;
	localparam logic [5:0] OFS_SIZE     = 6'd10;
	localparam logic [5:0] OFS_SEQUENCE = 6'd28;
	localparam logic [5:0] OFS_NAME     = 6'd33;

	// configuration register indexes
	localparam logic REG_NAME_LIMIT = 1'b0;
	localparam logic [7:0] NAME_LIMIT_RESET = 8'd255;

	typedef struct packed {
		logic [8:0]  avail;
		logic [7:0]  length_byte;
		logic [7:0]  flag_byte;
		logic        reserved_nonzero;
		logic [31:0] extent_value;
		logic        extent_mismatch;
		logic [31:0] size_value;
		logic        size_mismatch;
		logic [15:0] sequence_value;
		logic        sequence_mismatch;
		logic [7:0]  ident_length;
		logic [23:0] recent_name_bytes;
		logic        bad_char_seen;
	} rec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  error_offset;
		logic        dir_flag;
		logic        is_dot;
		logic        is_dotdot;
		logic [31:0] extent_lba;
		logic [31:0] byte_len;
		logic [7:0]  name_length;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/isodr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// isodr channel interfaces
// Valid/ready channels for record bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface isodr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] record_byte;
	logic       last;

	modport source (output valid, output record_byte, output last, input ready);
	modport sink (input valid, input record_byte, input last, output ready);
endinterface

interface isodr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  error_offset;
	logic        dir_flag;
	logic        is_dot;
	logic        is_dotdot;
	logic [31:0] extent_lba;
	logic [31:0] byte_len;
	logic [7:0]  name_length;

	modport source (output valid, output status, output error_offset, output dir_flag,
		output is_dot, output is_dotdot, output extent_lba, output byte_len,
		output name_length, input ready);
	modport sink (input valid, input status, input error_offset, input dir_flag,
		input is_dot, input is_dotdot, input extent_lba, input byte_len,
		input name_length, output ready);
endinterface
`default_nettype wire

/* rtl/core/isodr_capture.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// isodr_capture
// Byte position counter and fixed-field capture for one directory record.
// Presents the record state as it stands after the current byte.
// ----------------------------------------------------------------------------
module isodr_capture
	import isodr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic       last,
	input  wire logic [7:0] record_byte,
	output rec_t            rec_next
);

	logic [7:0] byte_count_q;
	rec_t       rec_q;
	rec_t       nxt;
	logic [8:0] name_end;
	logic       in_name;
	logic       bad_char;

	assign name_end = {1'b0, NAME_START} + {1'b0, rec_q.ident_length};
	assign in_name  = (byte_count_q >= NAME_START) && ({1'b0, byte_count_q} < name_end);
	assign bad_char = (record_byte < CHAR_LOW) || (record_byte > CHAR_HIGH) ||
		(record_byte == CHAR_SLASH) || (record_byte == CHAR_BACKSLASH) ||
		(record_byte == CHAR_COLON);

	always_comb begin
		nxt       = rec_q;
		nxt.avail = {1'b0, byte_count_q} + 9'd1;
		case (byte_count_q)
			POS_LENGTH: nxt.length_byte = record_byte;
			POS_EXT_ATTR, POS_UNIT_SIZE, POS_GAP_SIZE: begin
				if (record_byte != 8'd0) nxt.reserved_nonzero = 1'b1;
			end
			POS_EXT_LE0: nxt.extent_value[7:0]   = rec_q.extent_value[7:0] | record_byte;
			POS_EXT_LE1: nxt.extent_value[15:8]  = rec_q.extent_value[15:8] | record_byte;
			POS_EXT_LE2: nxt.extent_value[23:16] = rec_q.extent_value[23:16] | record_byte;
			POS_EXT_LE3: nxt.extent_value[31:24] = rec_q.extent_value[31:24] | record_byte;
			POS_EXT_BE0: begin
				if (rec_q.extent_value[31:24] != record_byte) nxt.extent_mismatch = 1'b1;
			end
			POS_EXT_BE1: begin
				if (rec_q.extent_value[23:16] != record_byte) nxt.extent_mismatch = 1'b1;
			end
			POS_EXT_BE2: begin
				if (rec_q.extent_value[15:8] != record_byte) nxt.extent_mismatch = 1'b1;
			end
			POS_EXT_BE3: begin
				if (rec_q.extent_value[7:0] != record_byte) nxt.extent_mismatch = 1'b1;
			end
			POS_SIZE_LE0: nxt.size_value[7:0]   = rec_q.size_value[7:0] | record_byte;
			POS_SIZE_LE1: nxt.size_value[15:8]  = rec_q.size_value[15:8] | record_byte;
			POS_SIZE_LE2: nxt.size_value[23:16] = rec_q.size_value[23:16] | record_byte;
			POS_SIZE_LE3: nxt.size_value[31:24] = rec_q.size_value[31:24] | record_byte;
			POS_SIZE_BE0: begin
				if (rec_q.size_value[31:24] != record_byte) nxt.size_mismatch = 1'b1;
			end
			POS_SIZE_BE1: begin
				if (rec_q.size_value[23:16] != record_byte) nxt.size_mismatch = 1'b1;
			end
			POS_SIZE_BE2: begin
				if (rec_q.size_value[15:8] != record_byte) nxt.size_mismatch = 1'b1;
			end
			POS_SIZE_BE3: begin
				if (rec_q.size_value[7:0] != record_byte) nxt.size_mismatch = 1'b1;
			end
			POS_FLAGS:   nxt.flag_byte = record_byte;
			POS_SEQ_LE0: nxt.sequence_value[7:0]  = rec_q.sequence_value[7:0] | record_byte;
			POS_SEQ_LE1: nxt.sequence_value[15:8] = rec_q.sequence_value[15:8] | record_byte;
			POS_SEQ_BE0: begin
				if (rec_q.sequence_value[15:8] != record_byte) nxt.sequence_mismatch = 1'b1;
			end
			POS_SEQ_BE1: begin
				if (rec_q.sequence_value[7:0] != record_byte) nxt.sequence_mismatch = 1'b1;
			end
			POS_IDENT_LEN: nxt.ident_length = record_byte;
			default: begin
				// identifier bytes: keep the last three, flag bad characters
				if (in_name) begin
					nxt.recent_name_bytes = {rec_q.recent_name_bytes[15:0], record_byte};
					if (bad_char) nxt.bad_char_seen = 1'b1;
				end
			end
		endcase
	end

	assign rec_next = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 8'd0;
			rec_q        <= '0;
		end else if (take) begin
			if (last) begin
				// verdict given on this byte: start a fresh record
				byte_count_q <= 8'd0;
				rec_q        <= '0;
			end else begin
				if (byte_count_q != 8'hFF) byte_count_q <= byte_count_q + 8'd1;
				rec_q <= nxt;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/isodr_verdict.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// isodr_verdict
// Decides status, error offset and reported fields from the record state
// after its last byte.
// ----------------------------------------------------------------------------
module isodr_verdict
	import isodr_pkg::*;
(
	input  wire rec_t       rec,
	input  wire logic [7:0] name_limit,
	output result_t         result
);

	logic       len_bad;
	logic       ident_bad;
	logic       unsupported;
	logic       isdir;
	logic [7:0] last_name_byte;
	logic       has_suffix;
	logic [7:0] name_len;
	logic [7:0] last_char;
	logic       unsafe;

	assign len_bad = (rec.avail < {1'b0, MIN_RECORD}) || (rec.length_byte < MIN_RECORD) ||
		({1'b0, rec.length_byte} > rec.avail);
	assign ident_bad = (rec.ident_length == 8'd0) ||
		(({1'b0, NAME_START} + {1'b0, rec.ident_length}) > {1'b0, rec.length_byte});
	assign unsupported    = rec.reserved_nonzero || rec.flag_byte[FLAG_MULTI];
	assign isdir          = rec.flag_byte[FLAG_DIRECTORY];
	assign last_name_byte = rec.recent_name_bytes[7:0];
	assign has_suffix     = (rec.ident_length >= 8'd3) &&
		(rec.recent_name_bytes[15:0] == SUFFIX_VERSION);

	always_comb begin
		if (isdir) begin
			name_len  = rec.ident_length;
			last_char = last_name_byte;
		end else begin
			name_len  = rec.ident_length - 8'd2;
			last_char = rec.recent_name_bytes[23:16];
		end
	end

	assign unsafe = (name_len > name_limit) || (last_char == CHAR_DOT) ||
		(last_char == CHAR_SPACE) || rec.bad_char_seen;

	always_comb begin
		result              = '0;
		result.status       = STAT_OK;
		result.error_offset = OFS_NONE;
		if (len_bad || ident_bad) begin
			result.status = STAT_INVALID;
		end else if (unsupported) begin
			result.status = STAT_UNSUPPORTED;
		end else if (rec.extent_mismatch) begin
			result.status       = STAT_INVALID;
			result.error_offset = OFS_EXTENT;
		end else if (rec.size_mismatch) begin
			result.status       = STAT_INVALID;
			result.error_offset = OFS_SIZE;
		end else if (rec.sequence_mismatch || (rec.sequence_value != 16'd1)) begin
			result.status       = STAT_INVALID;
			result.error_offset = OFS_SEQUENCE;
		end else begin
			result.dir_flag   = isdir;
			result.extent_lba = rec.extent_value;
			result.byte_len   = rec.size_value;
			if (rec.ident_length == 8'd1 && last_name_byte == IDENT_DOT) begin
				result.is_dot = 1'b1;
			end else if (rec.ident_length == 8'd1 && last_name_byte == IDENT_DOT_DOT) begin
				result.is_dotdot = 1'b1;
			end else if (!isdir && !has_suffix) begin
				result.status       = STAT_UNSUPPORTED;
				result.error_offset = OFS_NAME;
			end else begin
				result.name_length = name_len;
				if (unsafe) begin
					result.status       = STAT_UNSAFE;
					result.error_offset = OFS_NAME;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/iso9660_dir_record_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iso9660_dir_record_checker
// Streaming checker for one ISO9660 directory record per verdict.
// ----------------------------------------------------------------------------
// Usage:
//   rec carries one record byte per request, starting at the length byte;
//   last marks the final byte. A new byte may follow in the next cycle,
//   one byte per clock sustained while the skid register is empty.
//   Only the request with last high produces a verdict on res; the verdict
//   is registered into the output register, or the skid register if res is stalled.
//   The fields are captured into registers as they pass; the verdict is
//   computed in the same cycle as the last byte from the captured state.
//   If res is stalled, a second verdict is held in a skid register; rec
//   drops ready only while that skid register is occupied.
//   name_limit is written through the APB port at addresses 0 to 3 (paddr[2]
//   low; addresses 4 to 7 read as zero and ignore writes); write it while idle.
//   Reset clears the record state and the valid flags of both output
//   registers and sets name_limit to 255. The block is ready right after reset.
// ----------------------------------------------------------------------------
module iso9660_dir_record_checker
	import isodr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	isodr_in_if.sink         rec,
	isodr_out_if.source      res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [7:0] name_limit_q;
	logic       reg_sel;
	logic       take;
	logic       produce;
	rec_t       rec_next;
	result_t    verdict;
	result_t    out_q;
	result_t    skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       out_free;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_NAME_LIMIT);
	assign prdata  = reg_sel ? {24'd0, name_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_limit_q <= NAME_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			name_limit_q <= pwdata[7:0];
		end
	end

	// byte capture and verdict
	assign rec.ready = !skid_valid_q;
	assign take      = rec.valid && rec.ready;
	assign produce   = take && rec.last;

	isodr_capture u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.last        (rec.last),
		.record_byte (rec.record_byte),
		.rec_next    (rec_next)
	);

	isodr_verdict u_verdict (
		.rec        (rec_next),
		.name_limit (name_limit_q),
		.result     (verdict)
	);

	// output register with skid stage
	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (produce) out_q <= verdict;
		end else if (produce) begin
			skid_q <= verdict;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.status       = out_q.status;
	assign res.error_offset = out_q.error_offset;
	assign res.dir_flag     = out_q.dir_flag;
	assign res.is_dot       = out_q.is_dot;
	assign res.is_dotdot    = out_q.is_dotdot;
	assign res.extent_lba   = out_q.extent_lba;
	assign res.byte_len     = out_q.byte_len;
	assign res.name_length  = out_q.name_length;

	// assertions
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a verdict while the output is empty");

	a_verdict_lands: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> out_valid_q)
		else $error("accepted last byte produced no verdict");

	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STAT_OK) |-> (out_q.error_offset == OFS_NONE))
		else $error("ok verdict carries an error offset");

	a_unsafe_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STAT_UNSAFE) |-> (out_q.error_offset == OFS_NAME))
		else $error("unsafe name verdict not at the identifier offset");

	a_dot_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.is_dot && out_q.is_dotdot))
		else $error("record classed as both dot and dot-dot");

endmodule
`default_nettype wire

/* dv/tb_iso9660_dir_record_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iso9660_dir_record_checker
// Streams directory records, well formed and broken, into the checker one
// byte per request and compares every verdict field against a predictor
// kept in the scoreboard. The name limit is changed between phases while the
// block is idle. Both channels idle in random bursts, and the verdict side
// holds off for a long stretch once to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb_iso9660_dir_record_checker;
	import isodr_pkg::*;

	localparam logic [2:0] ADDR_NAME_LIMIT = {REG_NAME_LIMIT, 2'b00};
	localparam logic [2:0] ADDR_SPARE      = 3'd4;
	localparam int         LONG_HOLD       = 300;
	localparam int         PHASE_BYTES     = 50;

	typedef enum int {
		FLAW_NONE,
		FLAW_EXT_ATTR,
		FLAW_INTERLEAVE,
		FLAW_MULTI,
		FLAW_EXTENT,
		FLAW_SIZE,
		FLAW_SEQUENCE,
		FLAW_BAD_CHAR,
		FLAW_TRAIL_CHAR,
		FLAW_NO_SUFFIX,
		FLAW_IDENT_ZERO,
		FLAW_IDENT_LONG,
		FLAW_SHORT_LENGTH,
		FLAW_TRUNCATED,
		FLAW_NOISE
	} flaw_e;

	class verdict_board;
		logic [7:0]  name_limit;
		logic [7:0]  seen_count;
		logic [7:0]  rec_length;
		logic [7:0]  flags;
		bit          reserved_bad;
		logic [31:0] extent_le;
		bit          extent_bad;
		logic [31:0] size_le;
		bit          size_bad;
		logic [15:0] seq_le;
		bit          seq_bad;
		logic [7:0]  ident_len;
		logic [23:0] name_tail;
		bit          name_bad_char;
		result_t     expected_verdicts[$];
		int unsigned errors;

		function new();
			name_limit = NAME_LIMIT_RESET;
			errors = 0;
			clear_record();
		endfunction

		function void clear_record();
			seen_count = '0;
			rec_length = '0;
			flags = '0;
			reserved_bad = 0;
			extent_le = '0;
			extent_bad = 0;
			size_le = '0;
			size_bad = 0;
			seq_le = '0;
			seq_bad = 0;
			ident_len = '0;
			name_tail = '0;
			name_bad_char = 0;
		endfunction

		function void accept_byte(logic [7:0] b, logic is_last);
			int      pos;
			int      stem;
			bit      named;
			logic [7:0] tail_char;
			result_t v;

			pos = int'(seen_count);
			if (pos == POS_LENGTH) begin
				rec_length = b;
			end else if (pos == POS_EXT_ATTR || pos == POS_UNIT_SIZE || pos == POS_GAP_SIZE) begin
				if (b != 8'd0)
					reserved_bad = 1;
			end else if (pos >= POS_EXT_LE0 && pos <= POS_EXT_LE3) begin
				extent_le[8 * (pos - POS_EXT_LE0) +: 8] = b;
			end else if (pos >= POS_EXT_BE0 && pos <= POS_EXT_BE3) begin
				if (extent_le[8 * (POS_EXT_BE3 - pos) +: 8] != b)
					extent_bad = 1;
			end else if (pos >= POS_SIZE_LE0 && pos <= POS_SIZE_LE3) begin
				size_le[8 * (pos - POS_SIZE_LE0) +: 8] = b;
			end else if (pos >= POS_SIZE_BE0 && pos <= POS_SIZE_BE3) begin
				if (size_le[8 * (POS_SIZE_BE3 - pos) +: 8] != b)
					size_bad = 1;
			end else if (pos == POS_FLAGS) begin
				flags = b;
			end else if (pos == POS_SEQ_LE0 || pos == POS_SEQ_LE1) begin
				seq_le[8 * (pos - POS_SEQ_LE0) +: 8] = b;
			end else if (pos == POS_SEQ_BE0 || pos == POS_SEQ_BE1) begin
				if (seq_le[8 * (POS_SEQ_BE1 - pos) +: 8] != b)
					seq_bad = 1;
			end else if (pos == POS_IDENT_LEN) begin
				ident_len = b;
			end else if (pos >= NAME_START && pos < int'(NAME_START) + int'(ident_len)) begin
				name_tail = {name_tail[15:0], b};
				if (b < CHAR_LOW || b > CHAR_HIGH || b == CHAR_SLASH || b == CHAR_BACKSLASH
					|| b == CHAR_COLON)
					name_bad_char = 1;
			end
			if (seen_count != 8'd255)
				seen_count++;
			if (!is_last)
				return;

			v = '0;
			if (pos + 1 < MIN_RECORD || rec_length < MIN_RECORD || rec_length > pos + 1) begin
				v.status = STAT_INVALID;
			end else if (ident_len == 0 || int'(NAME_START) + int'(ident_len) > rec_length) begin
				v.status = STAT_INVALID;
			end else if (reserved_bad || flags[FLAG_MULTI]) begin
				v.status = STAT_UNSUPPORTED;
			end else if (extent_bad) begin
				v.status = STAT_INVALID;
				v.error_offset = OFS_EXTENT;
			end else if (size_bad) begin
				v.status = STAT_INVALID;
				v.error_offset = OFS_SIZE;
			end else if (seq_bad || seq_le != 16'd1) begin
				v.status = STAT_INVALID;
				v.error_offset = OFS_SEQUENCE;
			end else begin
				v.dir_flag = flags[FLAG_DIRECTORY];
				v.extent_lba = extent_le;
				v.byte_len = size_le;
				if (ident_len == 1 && name_tail[7:0] == IDENT_DOT) begin
					v.is_dot = 1'b1;
				end else if (ident_len == 1 && name_tail[7:0] == IDENT_DOT_DOT) begin
					v.is_dotdot = 1'b1;
				end else begin
					named = 1;
					stem = 0;
					tail_char = '0;
					if (v.dir_flag) begin
						stem = int'(ident_len);
						tail_char = name_tail[7:0];
					end else if (ident_len >= 3 && name_tail[15:0] == SUFFIX_VERSION) begin
						// strip the version suffix
						stem = int'(ident_len) - 2;
						tail_char = name_tail[23:16];
					end else begin
						named = 0;
						v.status = STAT_UNSUPPORTED;
						v.error_offset = OFS_NAME;
					end
					if (named) begin
						v.name_length = stem[7:0];
						if (stem > name_limit || tail_char == CHAR_DOT || tail_char == CHAR_SPACE
							|| name_bad_char) begin
							v.status = STAT_UNSAFE;
							v.error_offset = OFS_NAME;
						end
					end
				end
			end
			expected_verdicts.insert(expected_verdicts.size(), v);
			clear_record();
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("%0t: verdict %s mismatch: got %0h, expected %0h", $time, field, got, want);
			errors++;
		endtask

		task check_verdict(result_t got);
			result_t want;

			if (expected_verdicts.size() == 0) begin
				report("unexpected", 32'(got.status), 32'd0);
				return;
			end
			want = expected_verdicts.pop_front();
			if (got.status !== want.status)
				report("status", 32'(got.status), 32'(want.status));
			if (got.error_offset !== want.error_offset)
				report("error_offset", 32'(got.error_offset), 32'(want.error_offset));
			if (got.dir_flag !== want.dir_flag)
				report("dir_flag", 32'(got.dir_flag), 32'(want.dir_flag));
			if (got.is_dot !== want.is_dot)
				report("is_dot", 32'(got.is_dot), 32'(want.is_dot));
			if (got.is_dotdot !== want.is_dotdot)
				report("is_dotdot", 32'(got.is_dotdot), 32'(want.is_dotdot));
			if (got.extent_lba !== want.extent_lba)
				report("extent_lba", got.extent_lba, want.extent_lba);
			if (got.byte_len !== want.byte_len)
				report("byte_len", got.byte_len, want.byte_len);
			if (got.name_length !== want.name_length)
				report("name_length", 32'(got.name_length), 32'(want.name_length));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	isodr_in_if  rec_if();
	isodr_out_if res_if();

	verdict_board board = new();
	logic [7:0]   rec_bytes[$];
	bit           idle_enable = 1;
	int           hold_off_cycles = 0;
	int           phase_bytes = 0;

	iso9660_dir_record_checker DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec     (rec_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// note the byte before checking, in case a verdict lands on the same edge
	always @(posedge clk) begin : watch
		result_t got;

		if (rec_if.valid && rec_if.ready)
			board.accept_byte(rec_if.record_byte, rec_if.last);
		if (res_if.valid && res_if.ready) begin
			got.status = res_if.status;
			got.error_offset = res_if.error_offset;
			got.dir_flag = res_if.dir_flag;
			got.is_dot = res_if.is_dot;
			got.is_dotdot = res_if.is_dotdot;
			got.extent_lba = res_if.extent_lba;
			got.byte_len = res_if.byte_len;
			got.name_length = res_if.name_length;
			board.check_verdict(got);
		end
	end

	// verdict side: one ready assignment per edge at most
	initial begin : verdict_sink
		int n;

		forever begin
			if (hold_off_cycles != 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
				res_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_enable && $urandom_range(0, 7) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic is_last);
		if (idle_enable && $urandom_range(0, 9) == 0) begin
			rec_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rec_if.valid <= 1'b1;
		rec_if.record_byte <= b;
		rec_if.last <= is_last;
		@(posedge clk);
		while (!rec_if.ready)
			@(posedge clk);
	endtask

	task automatic send_record();
		foreach (rec_bytes[i])
			push_byte(rec_bytes[i], i == rec_bytes.size() - 1);
		phase_bytes += rec_bytes.size();
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drain every verdict, then give the block its latency
	task automatic settle();
		rec_if.valid <= 1'b0;
		while (board.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_name_limit(input logic [7:0] limit);
		logic [31:0] word;

		settle();
		word = $urandom;
		word[7:0] = limit;
		apb_write(ADDR_NAME_LIMIT, word);
		board.name_limit = limit;
		phase_bytes = 0;
	endtask

	function automatic void append_byte(input logic [7:0] b);
		rec_bytes.insert(rec_bytes.size(), b);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] c;

		c = 8'($urandom_range(CHAR_LOW, CHAR_HIGH));
		if (c == CHAR_SLASH || c == CHAR_BACKSLASH || c == CHAR_COLON)
			c = "_";
		return c;
	endfunction

	function automatic logic [7:0] bad_char();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, CHAR_LOW - 1));
			1: return 8'($urandom_range(CHAR_HIGH + 1, 255));
			2: return CHAR_SLASH;
			3: return CHAR_BACKSLASH;
			default: return CHAR_COLON;
		endcase
	endfunction

	function automatic logic [7:0] nonzero_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	// build a well-formed record: file names of three or more bytes get the version suffix
	function automatic void form_record(input int id_len, input bit dir);
		logic [31:0] ext;
		logic [31:0] sz;
		logic [7:0]  fl;
		int          extra;
		int          total;

		ext = pick_word();
		sz = pick_word();
		extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		total = NAME_START + id_len + extra;
		if (total > 255) begin
			extra = 255 - NAME_START - id_len;
			total = 255;
		end
		fl = 8'($urandom);
		fl[FLAG_MULTI] = 1'b0;
		fl[FLAG_DIRECTORY] = dir;
		rec_bytes.delete();
		append_byte(total[7:0]);
		append_byte(8'h00);
		for (int i = 0; i < 4; i++)
			append_byte(ext[8 * i +: 8]);
		for (int i = 3; i >= 0; i--)
			append_byte(ext[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			append_byte(sz[8 * i +: 8]);
		for (int i = 3; i >= 0; i--)
			append_byte(sz[8 * i +: 8]);
		repeat (7)
			append_byte(8'($urandom));
		append_byte(fl);
		append_byte(8'h00);
		append_byte(8'h00);
		append_byte(8'h01);
		append_byte(8'h00);
		append_byte(8'h00);
		append_byte(8'h01);
		append_byte(id_len[7:0]);
		repeat (id_len)
			append_byte(name_char());
		if (!dir && id_len >= 3) begin
			rec_bytes[NAME_START + id_len - 2] = SUFFIX_VERSION[15:8];
			rec_bytes[NAME_START + id_len - 1] = SUFFIX_VERSION[7:0];
		end
		repeat (extra)
			append_byte(8'($urandom));
	endfunction

	function automatic void apply_flaw(input flaw_e flaw);
		int         id_len;
		int         idx;
		int         cut;
		logic [15:0] seq;

		id_len = int'(rec_bytes[POS_IDENT_LEN]);
		case (flaw)
			FLAW_EXT_ATTR:
				rec_bytes[POS_EXT_ATTR] = nonzero_byte();
			FLAW_INTERLEAVE:
				rec_bytes[$urandom_range(0, 1) ? POS_UNIT_SIZE : POS_GAP_SIZE] = nonzero_byte();
			FLAW_MULTI:
				rec_bytes[POS_FLAGS] = rec_bytes[POS_FLAGS] | (8'h01 << FLAG_MULTI);
			FLAW_EXTENT: begin
				idx = $urandom_range(POS_EXT_BE0, POS_EXT_BE3);
				rec_bytes[idx] = rec_bytes[idx] ^ nonzero_byte();
			end
			FLAW_SIZE: begin
				idx = $urandom_range(POS_SIZE_BE0, POS_SIZE_BE3);
				rec_bytes[idx] = rec_bytes[idx] ^ nonzero_byte();
			end
			FLAW_SEQUENCE: begin
				if ($urandom_range(0, 1)) begin
					idx = $urandom_range(POS_SEQ_LE0, POS_SEQ_BE1);
					rec_bytes[idx] = rec_bytes[idx] ^ nonzero_byte();
				end else begin
					// consistent in both byte orders, but not volume one
					seq = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
					if (seq == 16'd1)
						seq = 16'd2;
					rec_bytes[POS_SEQ_LE0] = seq[7:0];
					rec_bytes[POS_SEQ_LE1] = seq[15:8];
					rec_bytes[POS_SEQ_BE0] = seq[15:8];
					rec_bytes[POS_SEQ_BE1] = seq[7:0];
				end
			end
			FLAW_BAD_CHAR:
				rec_bytes[NAME_START + $urandom_range(0, id_len - 1)] = bad_char();
			FLAW_TRAIL_CHAR: begin
				idx = (rec_bytes[POS_FLAGS][FLAG_DIRECTORY] || id_len < 3)
					? NAME_START + id_len - 1 : NAME_START + id_len - 3;
				rec_bytes[idx] = $urandom_range(0, 1) ? CHAR_DOT : CHAR_SPACE;
			end
			FLAW_NO_SUFFIX:
				rec_bytes[NAME_START + id_len - 1] = "2";
			FLAW_IDENT_ZERO:
				rec_bytes[POS_IDENT_LEN] = 8'd0;
			FLAW_IDENT_LONG:
				rec_bytes[POS_IDENT_LEN] =
					8'($urandom_range(rec_bytes[POS_LENGTH] - NAME_START + 1, 255));
			FLAW_SHORT_LENGTH:
				rec_bytes[POS_LENGTH] = 8'($urandom_range(0, MIN_RECORD - 1));
			FLAW_TRUNCATED: begin
				cut = $urandom_range(0, 1) ? $urandom_range(1, MIN_RECORD - 1)
					: $urandom_range(MIN_RECORD - 1, rec_bytes[POS_LENGTH] - 1);
				while (rec_bytes.size() > cut)
					void'(rec_bytes.pop_back());
			end
			FLAW_NOISE: begin
				rec_bytes.delete();
				repeat ($urandom_range(1, 48))
					append_byte(8'($urandom));
			end
			default: ;
		endcase
	endfunction

	task automatic random_record();
		int id_len;
		int roll;
		bit dir;

		dir = ($urandom_range(0, 2) == 0);
		roll = $urandom_range(0, 39);
		if (roll == 0)
			id_len = $urandom_range(100, 222);
		else if (roll <= 4)
			id_len = 1;
		else if (!dir && roll == 5)
			id_len = $urandom_range(1, 2);
		else
			id_len = $urandom_range(dir ? 1 : 3, 16);
		form_record(id_len, dir);
		if (roll >= 1 && roll <= 4)
			rec_bytes[NAME_START] = roll[0] ? IDENT_DOT : IDENT_DOT_DOT;
		if ($urandom_range(0, 2) == 0)
			apply_flaw(flaw_e'($urandom_range(FLAW_EXT_ATTR, FLAW_NOISE)));
		send_record();
	endtask

	initial begin
		rec_if.valid <= 1'b0;
		rec_if.record_byte <= '0;
		rec_if.last <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one record per flaw, at the reset limit
		for (int k = FLAW_NONE; k <= FLAW_NOISE; k++) begin
			form_record(6, 1'b0);
			apply_flaw(flaw_e'(k));
			send_record();
		end
		form_record(1, 1'b1);
		rec_bytes[NAME_START] = IDENT_DOT;
		send_record();
		form_record(1, 1'b0);
		rec_bytes[NAME_START] = IDENT_DOT_DOT;
		send_record();
		form_record(8, 1'b1);
		send_record();
		form_record(1, 1'b0);
		send_record();
		form_record(5, 1'b0);
		rec_bytes[NAME_START] = CHAR_LOW;
		rec_bytes[NAME_START + 1] = CHAR_HIGH;
		send_record();
		// run past the saturating byte count with trailing bytes
		form_record(222, 1'b1);
		repeat (10)
			append_byte(8'($urandom));
		send_record();

		set_name_limit(8'd1);
		settle();
		apb_write(ADDR_SPARE, $urandom);
		while (phase_bytes < PHASE_BYTES)
			random_record();

		set_name_limit(8'd0);
		// stall verdicts while short requests keep coming
		hold_off_cycles = LONG_HOLD;
		repeat (5) begin
			form_record(1, 1'b1);
			apply_flaw(FLAW_NOISE);
			send_record();
		end
		while (phase_bytes < PHASE_BYTES)
			random_record();

		set_name_limit(8'($urandom_range(2, 30)));
		while (phase_bytes < PHASE_BYTES)
			random_record();

		set_name_limit(8'd8);
		while (phase_bytes < PHASE_BYTES)
			random_record();

		set_name_limit(8'd12);
		while (phase_bytes < PHASE_BYTES)
			random_record();

		set_name_limit(8'd255);
		idle_enable = 0;
		while (phase_bytes < PHASE_BYTES)
			random_record();

		settle();
		repeat (6) @(posedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* iso9660_dir_record_checker.f */
rtl/core/isodr_pkg.sv
rtl/core/isodr_if.sv
rtl/core/isodr_capture.sv
rtl/core/isodr_verdict.sv
rtl/core/iso9660_dir_record_checker.sv
dv/tb_iso9660_dir_record_checker.sv
